// File: src/sks_pkg.sv
package sks_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  // Read address select for the entry store
  typedef enum logic [1:0] {
    RA_IDX  = 2'd0,
    RA_DEC  = 2'd1,
    RA_INC  = 2'd2,
    RA_NONE = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load;         // latch a new request, clear flags, idx = 0
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_from_cnt;
    logic    idx_from_pos;
    logic    pos_from_idx;
    logic    pos_from_inc;
    logic    found_set;    // found <= (read data == key)
    logic    wr_shift;     // mem[idx] <= read data
    logic    wr_key;       // mem[pos] <= key
    logic    cnt_inc;
    logic    cnt_dec;
    logic    changed_set;
    logic    refused_set;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic less;
    logic idx_last;       // idx + 1 == count
    logic idx_next_pos;   // idx - 1 == pos
    logic pos_at_cnt;     // pos == count
    logic is_insert;
    logic is_remove;
    logic found;
    logic out_busy;
  } status_t;

endpackage

// File: src/sorted_key_set.sv
// Channel | Direction | Ports                      | Contents
// in      | slave     | in_tvalid/tready/tdata/tuser | request: op, key
// out     | master     | out_tvalid/tready/tdata     | result: flags, position, count
//
// One request at a time. The search reads each stored key (read, then compare)
// through the single-port entry memory (registered read), then an insert moves
// the larger entries up one slot each (read, write) and a remove moves the later
// entries down one slot each (check, read, write).
// Reset empties the set; entry contents need no clearing.
// A finished result waits in the output register; a stalled out side holds
// the controller in its result state and the next request waits.
module sorted_key_set #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sks_pkg::KEY_IN_W-1:0]   in_tdata,   // [31:0] key
  input  logic [sks_pkg::OP_W-1:0]       in_tuser,   // [1:0] op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sks_pkg::OUT_DATA_W-1:0] out_tdata   // [0] found, [1] changed,
                                                     // [2] full_refused,
                                                     // [7:3] position, [12:8] count
);
  import sks_pkg::*;

  cmd_t    cmd;
  status_t sts;

  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sks_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_key     (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/sks_ctrl.sv
module sks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sks_pkg::status_t sts,
  output sks_pkg::cmd_t    cmd
);
  import sks_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SRD  = 11'b000_0000_0010,
    S_SCMP = 11'b000_0000_0100,
    S_DEC  = 11'b000_0000_1000,
    S_IRD  = 11'b000_0001_0000,
    S_IWR  = 11'b000_0010_0000,
    S_IPUT = 11'b000_0100_0000,
    S_RCHK = 11'b000_1000_0000,
    S_RRD  = 11'b001_0000_0000,
    S_RWR  = 11'b010_0000_0000,
    S_RES  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RA_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        // empty store: nothing to scan
        if (sts.cnt_zero) begin
          state_nxt = S_DEC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.less) begin
          if (sts.idx_last) begin
            cmd.pos_from_inc = 1'b1;
            state_nxt        = S_DEC;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SRD;
          end
        end else begin
          cmd.pos_from_idx = 1'b1;
          cmd.found_set    = 1'b1;
          state_nxt        = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_insert && !sts.found) begin
          if (sts.cnt_full) begin
            cmd.refused_set = 1'b1;
            state_nxt       = S_RES;
          end else if (sts.pos_at_cnt) begin
            state_nxt = S_IPUT;
          end else begin
            cmd.idx_from_cnt = 1'b1;
            state_nxt        = S_IRD;
          end
        end else if (sts.is_remove && sts.found) begin
          cmd.idx_from_pos = 1'b1;
          state_nxt        = S_RCHK;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_IRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_DEC;
        state_nxt  = S_IWR;
      end
      S_IWR: begin
        // move one larger key up a slot
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = sts.idx_next_pos ? S_IPUT : S_IRD;
      end
      S_IPUT: begin
        cmd.wr_key      = 1'b1;
        cmd.cnt_inc     = 1'b1;
        cmd.changed_set = 1'b1;
        state_nxt       = S_RES;
      end
      S_RCHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec     = 1'b1;
          cmd.changed_set = 1'b1;
          state_nxt       = S_RES;
        end else begin
          state_nxt = S_RRD;
        end
      end
      S_RRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_INC;
        state_nxt  = S_RWR;
      end
      S_RWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_RCHK;
      end
      S_RES: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/sks_dp.sv
module sks_dp #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sks_pkg::OP_W-1:0]          in_op,
  input  logic [sks_pkg::KEY_IN_W-1:0]      in_key,
  input  sks_pkg::cmd_t                     cmd,
  output sks_pkg::status_t                  sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sks_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sks_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] mem [0:CAPACITY-1];

  logic [OP_W-1:0]      op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] rdata_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        pos_r;
  logic [IW-1:0]        cnt_r;
  logic                 found_r;
  logic                 changed_r;
  logic                 refused_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [KEY_WIDTH+KEY_IN_W-1:0] key_ext;
  logic [IW-1:0]        idx_inc;
  logic [IW-1:0]        idx_dec;
  logic [IW-1:0]        raddr;
  logic [IW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [IW+POS_W-1:0]  pos_ext;
  logic [IW+CNT_W-1:0]  cnt_ext;

  // keep only the low KEY_WIDTH bits of the incoming key
  assign key_ext = {{KEY_WIDTH{1'b0}}, in_key};
  assign idx_inc = idx_r + IW'(1);
  assign idx_dec = idx_r - IW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RA_DEC:  raddr = idx_dec;
      RA_INC:  raddr = idx_inc;
      default: raddr = idx_r;
    endcase
  end

  assign waddr = cmd.wr_key ? pos_r : idx_r;
  assign wdata = cmd.wr_key ? key_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr[AW-1:0]];
    end
    if (cmd.wr_shift || cmd.wr_key) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= key_ext[KEY_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      changed_r   <= 1'b0;
      refused_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        pos_r     <= '0;
        found_r   <= 1'b0;
        changed_r <= 1'b0;
        refused_r <= 1'b0;
      end else begin
        if (cmd.idx_inc)      idx_r <= idx_inc;
        if (cmd.idx_dec)      idx_r <= idx_dec;
        if (cmd.idx_from_cnt) idx_r <= cnt_r;
        if (cmd.idx_from_pos) idx_r <= pos_r;
        if (cmd.pos_from_idx) pos_r <= idx_r;
        if (cmd.pos_from_inc) pos_r <= idx_inc;
        if (cmd.found_set)    found_r <= (rdata_r == key_r);
        if (cmd.changed_set)  changed_r <= 1'b1;
        if (cmd.refused_set)  refused_r <= 1'b1;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + IW'(1);
      if (cmd.cnt_dec) cnt_r <= cnt_r - IW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, pos_r};
  assign cnt_ext = {{CNT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'b000, cnt_ext[CNT_W-1:0], pos_ext[POS_W-1:0],
                     refused_r, changed_r, found_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.cnt_zero     = (cnt_r == '0);
  assign sts.cnt_full     = (cnt_r == IW'(CAPACITY));
  assign sts.less         = (rdata_r < key_r);
  assign sts.idx_last     = (idx_inc == cnt_r);
  assign sts.idx_next_pos = (idx_dec == pos_r);
  assign sts.pos_at_cnt   = (pos_r == cnt_r);
  assign sts.is_insert    = (op_r == OP_INSERT);
  assign sts.is_remove    = (op_r == OP_REMOVE);
  assign sts.found        = found_r;
  assign sts.out_busy     = out_valid_r && !out_tready;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

import sks_pkg::*;

typedef struct packed {
  logic             found;
  logic             changed;
  logic             refused;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] count;
} set_result_t;

// Shadow copy of the sorted set plus the queue of results still owed by the block.
class key_set_ledger #(int unsigned DEPTH = 16);
  logic [KEY_IN_W-1:0] held_keys[$];
  set_result_t         owed[$];
  int                  errors;
  int                  op_tally[4];
  int                  hits;
  int                  changes;
  int                  refusals;
  int                  peak_count;

  function void note_request(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key);
    set_result_t r;
    int unsigned pos;
    pos = 0;
    r = '0;
    while (pos < held_keys.size() && held_keys[pos] < key) pos++;
    r.found = pos < held_keys.size() && held_keys[pos] == key;
    if (op == OP_INSERT && !r.found) begin
      if (held_keys.size() >= DEPTH) begin
        r.refused = 1'b1;
      end else begin
        held_keys.insert(pos, key);
        r.changed = 1'b1;
      end
    end else if (op == OP_REMOVE && r.found) begin
      held_keys.delete(pos);
      r.changed = 1'b1;
    end
    r.position = pos[POS_W-1:0];
    r.count = CNT_W'(held_keys.size());
    op_tally[op]++;
    hits += r.found;
    changes += r.changed;
    refusals += r.refused;
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
    owed.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [OUT_DATA_W-1:0] beat);
    set_result_t want;
    if (owed.size() == 0) begin
      $error("result transfer with no request outstanding: %h", beat);
      errors++;
      return;
    end
    want = owed.pop_front();
    compare_field("found", want.found, beat[0]);
    compare_field("changed", want.changed, beat[1]);
    compare_field("full_refused", want.refused, beat[2]);
    compare_field("position", want.position, beat[7:3]);
    compare_field("count", want.count, beat[12:8]);
  endfunction

  function int outstanding();
    return owed.size();
  endfunction
endclass

module tb;
  localparam int unsigned SET_CAPACITY = 16;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [KEY_IN_W-1:0]   in_tdata = '0;    // [31:0] key
  logic [OP_W-1:0]       in_tuser = OP_FIND; // [1:0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [0] found, [1] changed, [2] full_refused,
                                           // [7:3] position, [12:8] count

  key_set_ledger #(SET_CAPACITY) ledger;
  int burst_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;
  int unsigned cycles = 0;

  sorted_key_set #(.CAPACITY(SET_CAPACITY), .KEY_WIDTH(32)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed", cycles,
               ledger.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready value from a
  // stall mode that is redrawn at random each time the stall phase wraps.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tdata);
    if (stall_phase == 0) stall_mode = $urandom_range(0, 3);
    stall_phase = (stall_phase + 1) % 48;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 3) != 0;
      2: out_tready <= $urandom_range(0, 2) == 0;
      default: out_tready <= (stall_phase % 5) < 2;
    endcase
  end

  // Hold the request until it transfers; bursts of random length, mostly with idle gaps between.
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    ledger.note_request(op, key);
  endtask

  task automatic run_directed();
    send_request(OP_FIND, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_SPARE, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h7FFF_FFFF);
    // fill to capacity, each new key landing just above zero
    for (int i = 13; i >= 1; i--) send_request(OP_INSERT, i * 32'h0111_1111 + 1);
    send_request(OP_INSERT, 32'h1234_5678);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_FIND, 32'h1234_5678);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_SPARE, 32'h8000_0000);
  endtask

  task automatic run_random(int unsigned n);
    logic [KEY_IN_W-1:0] key_pool[20];
    logic [KEY_IN_W-1:0] base;
    logic [OP_W-1:0]     op;
    logic [KEY_IN_W-1:0] key;
    int ins_w;
    int rem_w;
    int r;
    for (int unsigned k = 0; k < n; k++) begin
      // new key pool and operation mix every 50 requests
      if (k % 50 == 0) begin
        base = $urandom;
        for (int i = 0; i < 20; i++) begin
          case ($urandom_range(0, 3))
            0: key_pool[i] = $urandom;
            1: key_pool[i] = base + i;
            2: key_pool[i] = i;
            default: key_pool[i] = ~i;
          endcase
        end
        case ($urandom_range(0, 2))
          0: begin ins_w = 55; rem_w = 20; end
          1: begin ins_w = 15; rem_w = 55; end
          default: begin ins_w = 35; rem_w = 35; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < ins_w) op = OP_INSERT;
      else if (r < ins_w + rem_w) op = OP_REMOVE;
      else if (r < 95) op = OP_FIND;
      else op = OP_SPARE;
      key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 19)] : $urandom;
      send_request(op, key);
    end
  endtask

  initial begin
    ledger = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Requests: %0d insert, %0d remove, %0d find, %0d spare code",
             ledger.op_tally[OP_INSERT], ledger.op_tally[OP_REMOVE],
             ledger.op_tally[OP_FIND], ledger.op_tally[OP_SPARE]);
    $display("Hits %0d, set changes %0d, refused inserts %0d, peak occupancy %0d of %0d",
             ledger.hits, ledger.changes, ledger.refusals, ledger.peak_count,
             SET_CAPACITY);
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/sks_pkg.sv
src/sks_ctrl.sv
src/sks_dp.sv
src/sorted_key_set.sv
verif/tb.sv
